// ===== src/qdd_pkg.sv =====
// shared types, constants and the transition table for the detent decoder
package qdd_pkg;

    localparam int WRAP_LIMIT_DEF = 100;

    localparam int POS_W   = 8;
    localparam int QUAD_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 8;

    // register indexes of the configuration port
    localparam logic [CIDX_W-1:0] REG_USE_MIN   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_LIMIT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_USE_MAX   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_MAX_LIMIT = 2'd3;

    localparam logic [QUAD_W-1:0] QUAD_RESET = 2'b11;

    typedef struct packed {
        logic                    use_min;
        logic signed [POS_W-1:0] min_limit;
        logic                    use_max;
        logic signed [POS_W-1:0] max_limit;
    } cfg_t;

    typedef struct packed {
        logic                    hit;
        logic                    moved_up;
        logic signed [POS_W-1:0] delta;
    } res_t;

    // step for a pin transition, only four transitions count
    function automatic logic signed [1:0] step_delta(input logic [QUAD_W-1:0] last_q,
                                                     input logic [QUAD_W-1:0] q);
        logic signed [1:0] d;
        unique case ({last_q, q})
            4'b0100: d = 2'sd1;
            4'b0111: d = -2'sd1;
            4'b1000: d = -2'sd1;
            4'b1011: d = 2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/quadrature_detent_decoder_top.sv =====
// top level of the quadrature detent decoder: input stage, config registers, result register
// a word accepted into the input register reaches out_valid through the result register
// throughput: one word per cycle unless a result meets an untaken one; the position update
// is one table lookup, add and clamp between the input register and the result register
// a word with no detent change gives no result and does not wait for the output side
// reset (rst_n low, async): pins seen as both high, position and detent zero, config zero
module quadrature_detent_decoder_top
    import qdd_pkg::*;
#(
    parameter int WRAP_LIMIT = WRAP_LIMIT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // sample channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [QUAD_W-1:0]        quad_bits,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     moved_up,
    output logic signed [POS_W-1:0]  detent_delta,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CDATA_W-1:0]       cfg_data
);

    // configuration registers
    cfg_t cfg_reg;

    // input stage
    logic              s1_valid_reg;
    logic [QUAD_W-1:0] s1_quad_reg;

    // result register
    logic                    out_valid_reg;
    logic                    moved_up_reg;
    logic signed [POS_W-1:0] delta_reg;

    res_t res;
    logic advance;

    // the input word moves on when it gives no result or the result register has room
    assign advance  = s1_valid_reg && (!res.hit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_USE_MIN:   cfg_reg.use_min   <= cfg_data[0];
                REG_MIN_LIMIT: cfg_reg.min_limit <= cfg_data;
                REG_USE_MAX:   cfg_reg.use_max   <= cfg_data[0];
                REG_MAX_LIMIT: cfg_reg.max_limit <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_quad_reg <= quad_bits;
        end
    end

    // position, detent and pin state
    qdd_core #(
        .WRAP_LIMIT (WRAP_LIMIT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .quad  (s1_quad_reg),
        .fire  (advance),
        .res   (res)
    );

    // result register, loaded only when the detent count changed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.hit)
        begin
            moved_up_reg <= res.moved_up;
            delta_reg    <= res.delta;
        end
    end

    assign out_valid    = out_valid_reg;
    assign moved_up     = moved_up_reg;
    assign detent_delta = delta_reg;

endmodule

// ===== src/qdd_core.sv =====
// decoder state and the single pass position / detent update
module qdd_core
    import qdd_pkg::*;
#(
    parameter int WRAP_LIMIT = WRAP_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic [QUAD_W-1:0] quad,
    input  logic              fire,
    output res_t              res
);

    localparam logic signed [POS_W-1:0] WRAP_POS = POS_W'(WRAP_LIMIT);
    localparam logic signed [POS_W-1:0] WRAP_NEG = -POS_W'(WRAP_LIMIT);

    logic [QUAD_W-1:0]       last_quad_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [POS_W-1:0] reported_reg;

    logic signed [POS_W:0]   p_sum;
    logic signed [POS_W:0]   p_clamp;
    logic signed [POS_W:0]   min_ext;
    logic signed [POS_W:0]   max_ext;
    logic signed [POS_W-1:0] pos_step;
    logic signed [POS_W-1:0] pos_round;
    logic signed [POS_W-1:0] detent;
    logic signed [POS_W-1:0] diff;
    logic                    wrap;
    logic signed [POS_W-1:0] pos_next;
    logic signed [1:0]       d;

    always_comb
    begin
        d       = step_delta(last_quad_reg, quad);
        p_sum   = {pos_reg[POS_W-1], pos_reg} + {{(POS_W-1){d[1]}}, d};
        min_ext = $signed({cfg.min_limit[POS_W-1], cfg.min_limit});
        max_ext = $signed({cfg.max_limit[POS_W-1], cfg.max_limit});
        p_clamp = p_sum;
        if (cfg.use_min && (p_clamp < min_ext))
        begin
            p_clamp = min_ext;
        end
        if (cfg.use_max && (p_clamp > max_ext))
        begin
            p_clamp = max_ext;
        end
        // saturate to 8 bit signed
        if (p_clamp > (POS_W+1)'(127))
        begin
            pos_step = 8'sd127;
        end
        else if (p_clamp < -(POS_W+1)'(128))
        begin
            pos_step = -8'sd128;
        end
        else
        begin
            pos_step = p_clamp[POS_W-1:0];
        end
        if (quad == last_quad_reg)
        begin
            pos_step = pos_reg;
        end
        // divide by two, truncated toward zero
        pos_round = pos_step + POS_W'(pos_step[POS_W-1]);
        detent    = pos_round >>> 1;
        diff      = detent - reported_reg;
        wrap      = (pos_step > WRAP_POS) || (pos_step < WRAP_NEG);
        res.hit      = (diff != '0);
        res.moved_up = res.hit && !diff[POS_W-1];
        res.delta    = diff;
        pos_next     = (res.hit && wrap) ? '0 : pos_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_quad_reg <= QUAD_RESET;
            pos_reg       <= '0;
            reported_reg  <= '0;
        end
        else if (fire)
        begin
            last_quad_reg <= quad;
            pos_reg       <= pos_next;
            reported_reg  <= detent;
        end
    end

    // state holds while no word is processed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pos_reg) && $stable(reported_reg) && $stable(last_quad_reg))
        else $error("decoder state changed without a word");

    // a word that gives no result leaves the reported detent unchanged
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !res.hit |=> reported_reg == $past(reported_reg))
        else $error("reported detent moved without a result");

    // a zeroed position only follows a result beyond the wrap limit
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !res.hit && (pos_step != '0) |=> pos_reg != '0)
        else $error("position zeroed without a result");

endmodule

// ===== verif/tb_quadrature_detent_decoder_top.sv =====
// testbench for the quadrature detent decoder: directed and random pin walks checked per word
`timescale 1ns / 1ps

module tb_quadrature_detent_decoder_top;
    import qdd_pkg::*;

    localparam int     CLK_HALF_NS   = 5;
    localparam int     RESET_CYCLES  = 11;
    // margin after acceptance for a sample word to pass the input and the result register
    localparam int     SETTLE_CYCLES = 6;
    // a clean run ends well within this limit even with stalls
    localparam longint RUN_LIMIT_NS  = 64'd2_000_000;
    localparam int     GAP_PCT       = 11;

    // one detent report as it should leave the block
    typedef struct {
        logic                    moved_up;
        logic signed [POS_W-1:0] delta;
    } detent_move_t;

    // detent predictor plus the queue of reports still owed by the block
    class detent_checker;
        bit                use_min;
        int                min_lim;
        bit                use_max;
        int                max_lim;
        logic [QUAD_W-1:0] last_pins;
        int                position;
        int                shown_detent;
        int                step_lut[4][4];
        detent_move_t      detent_moves[$];
        int                failures;

        function new();
            // row: previous pins, column: new pins
            step_lut     = '{'{0, 0, 0, 0}, '{1, 0, 0, -1}, '{-1, 0, 0, 1}, '{0, 0, 0, 0}};
            last_pins    = QUAD_RESET;
            position     = 0;
            shown_detent = 0;
            failures     = 0;
        endfunction

        function void apply_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
            case (idx)
                REG_USE_MIN:   use_min = data[0];
                REG_MIN_LIMIT: min_lim = int'($signed(data));
                REG_USE_MAX:   use_max = data[0];
                REG_MAX_LIMIT: max_lim = int'($signed(data));
                default: ;
            endcase
        endfunction

        function void note_sample(input logic [QUAD_W-1:0] q);
            int           pos;
            int           detent;
            int           diff;
            detent_move_t move;
            if (q != last_pins) begin
                pos = position + step_lut[last_pins][q];
                if (use_min && pos < min_lim) pos = min_lim;
                if (use_max && pos > max_lim) pos = max_lim;
                if (pos > 127) pos = 127;
                if (pos < -128) pos = -128;
                position  = pos;
                last_pins = q;
            end
            detent = position / 2;
            if (detent != shown_detent) begin
                diff          = detent - shown_detent;
                move.moved_up = (diff > 0);
                move.delta    = diff[POS_W-1:0];
                detent_moves.push_back(move);
                // wrap zeroing only on a reporting word, detent keeps the pre-wrap count
                if (position > WRAP_LIMIT_DEF || position < -WRAP_LIMIT_DEF) position = 0;
                shown_detent = detent;
            end
        endfunction

        function void check_result(input logic up, input logic signed [POS_W-1:0] delta);
            detent_move_t want;
            if (detent_moves.size() == 0) begin
                $error("unexpected result word: moved_up %0d detent_delta %0d", up, delta);
                failures++;
                return;
            end
            want = detent_moves.pop_front();
            if (up !== want.moved_up) begin
                $error("moved_up: expected %0d, actual %0d", want.moved_up, up);
                failures++;
            end
            if (delta !== want.delta) begin
                $error("detent_delta: expected %0d, actual %0d", want.delta, delta);
                failures++;
            end
        endfunction

        function int pending();
            return detent_moves.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [QUAD_W-1:0]       quad_bits;
    logic                    out_valid;
    logic                    out_ready;
    logic                    moved_up;
    logic signed [POS_W-1:0] detent_delta;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CIDX_W-1:0]       cfg_index;
    logic [CDATA_W-1:0]      cfg_data;

    detent_checker     sb;
    int                send_gap_pct;    // chance in percent of an idle cycle on the sample side
    int                take_gap_pct;    // chance in percent of a stall on the result side
    int                samples_sent;
    logic [QUAD_W-1:0] pins_now;        // last pin pair handed to the block

    quadrature_detent_decoder_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .quad_bits    (quad_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .moved_up     (moved_up),
        .detent_delta (detent_delta),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF_NS;
        clk = 1'b1;
        #CLK_HALF_NS;
    end

    // result side: ready changes at the falling edge, words are taken at the rising edge
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= take_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(moved_up, detent_delta);
        end
    end

    // next pin pair one quarter step along the gray sequence
    function automatic logic [QUAD_W-1:0] next_pins(input logic [QUAD_W-1:0] p, input bit up);
        logic [QUAD_W-1:0] n;
        if (up)
        begin
            case (p)
                2'b11:   n = 2'b01;
                2'b01:   n = 2'b00;
                2'b00:   n = 2'b10;
                default: n = 2'b11;
            endcase
        end
        else
        begin
            case (p)
                2'b11:   n = 2'b10;
                2'b10:   n = 2'b00;
                2'b00:   n = 2'b01;
                default: n = 2'b11;
            endcase
        end
        return n;
    endfunction

    // hand one sample word to the block; entered and left at a falling edge
    task automatic send_sample(input logic [QUAD_W-1:0] q);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        quad_bits = q;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(q);
        pins_now = q;
        samples_sent++;
        @(negedge clk);
    endtask

    // rotate the knob by a number of quarter steps
    task automatic turn(input bit up, input int quarters);
        repeat (quarters) send_sample(next_pins(pins_now, up));
    endtask

    // hold off new samples until every owed report is out and the pipe is empty
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input bit lo_on, input logic [CDATA_W-1:0] lo,
                              input bit hi_on, input logic [CDATA_W-1:0] hi);
        settle();
        set_reg(REG_USE_MIN, {7'd0, lo_on});
        set_reg(REG_MIN_LIMIT, lo);
        set_reg(REG_USE_MAX, {7'd0, hi_on});
        set_reg(REG_MAX_LIMIT, hi);
    endtask

    // mostly clean rotations of random length and direction, some chatter, noise and holds
    task automatic wander(input int n_items);
        int stop;
        int pick;
        int len;
        stop = samples_sent + n_items;
        while (samples_sent < stop)
        begin
            pick = int'($urandom_range(99));
            len  = int'($urandom_range(1, 4));
            if (pick < 70)
                turn(1'($urandom_range(1)), int'($urandom_range(1, 40)));
            else if (pick < 80)
            begin
                // contact bounce around one edge
                repeat (len)
                begin
                    turn(1'b1, 1);
                    turn(1'b0, 1);
                end
            end
            else if (pick < 90)
                repeat (len) send_sample(QUAD_W'($urandom_range(3)));
            else
                repeat (len) send_sample(pins_now);
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        quad_bits    = QUAD_RESET;
        cfg_valid    = 1'b0;
        cfg_index    = REG_USE_MIN;
        cfg_data     = '0;
        send_gap_pct = GAP_PCT;
        take_gap_pct = GAP_PCT;
        samples_sent = 0;
        pins_now     = QUAD_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: clamps off after reset, pins start both high
        send_sample(2'b11);                 // same as reset pins, nothing moves
        turn(1'b1, 4);                      // one detent up
        turn(1'b0, 4);                      // one detent down
        send_sample(2'b00);                 // diagonal jumps and a non-counting step, all silent
        send_sample(2'b11);
        send_sample(2'b01);
        send_sample(2'b10);
        send_sample(2'b01);

        // a new limit waits for the next pin change
        settle();
        set_reg(REG_USE_MAX, 8'd1);
        set_reg(REG_MAX_LIMIT, 8'hfc);      // -4
        send_sample(2'b01);                 // pins unchanged, limit not applied yet
        send_sample(2'b00);                 // counting step, clamped down to -4

        // conflicting limits, upper clamp wins
        settle();
        set_reg(REG_USE_MIN, 8'd1);
        set_reg(REG_MIN_LIMIT, 8'h7f);      // 127
        send_sample(2'b10);                 // silent change still goes through the clamps
        settle();
        set_reg(REG_MAX_LIMIT, 8'h80);      // -128
        send_sample(2'b11);                 // lands at -128, reported and wrapped to zero
        send_sample(2'b11);                 // no pin change, still reports the jump back

        // clamps off, long runs past the wrap limit in both directions
        set_limits(1'b0, 8'h00, 1'b0, 8'h00);
        turn(1'b1, 212);
        turn(1'b0, 212);

        // widest limits, with a full drain halfway through
        set_limits(1'b1, 8'h80, 1'b1, 8'h7f);
        wander(75);
        settle();
        wander(75);

        // narrow window, no idling on either side
        send_gap_pct = 0;
        take_gap_pct = 0;
        set_limits(1'b1, 8'hfa, 1'b1, 8'h09);
        wander(150);
        send_gap_pct = GAP_PCT;
        take_gap_pct = GAP_PCT;

        // crossed limits
        set_limits(1'b1, 8'h7f, 1'b1, 8'h80);
        wander(100);

        repeat (3)
        begin
            set_limits(1'($urandom_range(1)), CDATA_W'($urandom_range(255)),
                       1'($urandom_range(1)), CDATA_W'($urandom_range(255)));
            wander(100);
        end

        // lower clamp only, upper limit set but unused
        set_limits(1'b1, 8'hec, 1'b0, CDATA_W'($urandom_range(255)));
        wander(100);

        settle();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/qdd_pkg.sv
src/qdd_core.sv
src/quadrature_detent_decoder_top.sv
verif/tb_quadrature_detent_decoder_top.sv
